### rtl/rnes_pkg.sv
package rnes_pkg;

	localparam int MAX_BASIS = 8;
	localparam int IDX_W     = $clog2(MAX_BASIS);
	localparam int CNT_W     = $clog2(MAX_BASIS + 1);

	localparam logic [3:0] REG_REGULARIZATION = 4'd0;
	localparam logic [3:0] REG_BASIS_COUNT    = 4'd1;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ACC, ST_DRAIN, ST_REG, ST_PIV_INIT, ST_PIV_SCAN, ST_SWAP, ST_CHECK,
		ST_DIV_GO, ST_DIV_WAIT, ST_MUL_GO, ST_MUL_WAIT, ST_BK_CHECK, ST_BK_DIV_GO,
		ST_BK_DIV_WAIT, ST_BK_MUL_GO, ST_BK_MUL_WAIT, ST_EMIT
	} st_t;

	typedef struct packed {
		logic              start;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} op_req_t;

	typedef struct packed {
		logic              done;
		logic signed [63:0] res;
	} op_rsp_t;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag(logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] to_signed(logic [63:0] m, logic neg, logic ovf);
		if (neg) begin
			if (ovf || m[63]) return SMIN;
			return -$signed(m);
		end
		if (ovf || m[63]) return SMAX;
		return $signed(m);
	endfunction

endpackage

### rtl/ridge_normal_equation_solver_core.sv
// Channel   Direction  Handshake                      Payload
// request   in         start & !busy                  elem_0..elem_7, rhs, last_row
// config    in         cfg_wr_en                      cfg_index, cfg_data
// result    out        coef_valid (one cycle)         coef_index, coef_value, zero_pivot,
//                                                     last_coef
//
// A request holds busy while eight lanes, one per matrix row, each own a
// 32x32 multiplier and walk the nine columns (eight basis terms and the target)
// one per cycle, and then while the product register drains. The next request
// is taken once the block is back in idle.
// A last row then runs the solve on one shared multi-cycle multiplier and
// one bit-serial divider, each started from an issue state; one division per
// eliminated row and per back-substituted column dominates the total.
// Coefficients leave one per cycle; the receiver cannot stall them.
// Reset clears all stores at once; the block is ready right after reset.
module ridge_normal_equation_solver_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] elem_0,
	input  logic signed [31:0] elem_1,
	input  logic signed [31:0] elem_2,
	input  logic signed [31:0] elem_3,
	input  logic signed [31:0] elem_4,
	input  logic signed [31:0] elem_5,
	input  logic signed [31:0] elem_6,
	input  logic signed [31:0] elem_7,
	input  logic signed [31:0] rhs,
	input  logic               last_row,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               coef_valid,
	output logic [2:0]         coef_index,
	output logic signed [63:0] coef_value,
	output logic               zero_pivot,
	output logic               last_coef
);
	localparam int NB = rnes_pkg::MAX_BASIS;
	localparam int IW = rnes_pkg::IDX_W;
	localparam int CW = rnes_pkg::CNT_W;

	rnes_pkg::st_t state_q, state_d;

	logic [31:0]        reg_q;
	logic [3:0]         bcount_q;
	logic [CW-1:0]      n;

	logic signed [63:0] mat_q [NB][NB];
	logic signed [63:0] vec_q [NB];
	logic signed [31:0] row_q [NB];
	logic signed [31:0] t_q;
	logic               last_q;

	logic [CW-1:0] j_q, j_s1, col_q, r_q, k_q, piv_q, i_q;
	logic          v_s1;
	logic signed [63:0] f_q;

	logic signed [31:0] lane_b;
	logic signed [63:0] lane_acc [NB];
	logic signed [63:0] lane_sum [NB];

	rnes_pkg::op_req_t mul_req, div_req;
	rnes_pkg::op_rsp_t mul_rsp, div_rsp;

	logic accept;
	logic col_more, r_more, k_more, diag_zero;

	assign accept = start && !busy;
	assign busy   = state_q != rnes_pkg::ST_IDLE;

	// Clamp the basis count: zero acts as one, anything above the lanes as all.
	always_comb begin
		if (bcount_q == 4'd0) n = CW'(1);
		else if (bcount_q > 4'(NB)) n = CW'(NB);
		else n = CW'(bcount_q);
	end

	assign col_more  = (col_q + CW'(1)) < n;
	assign r_more    = (r_q + CW'(1)) < n;
	assign k_more    = k_q < n;
	assign diag_zero = mat_q[col_q[IW-1:0]][col_q[IW-1:0]] == 64'sd0;

	// Lanes: lane i accumulates row i, column j_q (target on the extra column).
	assign lane_b = (j_q < CW'(NB)) ? row_q[j_q[IW-1:0]] : t_q;

	for (genvar g = 0; g < NB; g++) begin : g_lane
		assign lane_acc[g] = (j_s1 < CW'(NB)) ? mat_q[g][j_s1[IW-1:0]] : vec_q[g];
		rnes_lane u_lane (
			.clk (clk),
			.a   (row_q[g]),
			.b   (lane_b),
			.acc (lane_acc[g]),
			.sum (lane_sum[g])
		);
	end

	rnes_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	rnes_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rnes_pkg::ST_IDLE:     if (accept) state_d = rnes_pkg::ST_ACC;
			rnes_pkg::ST_ACC:      if (j_q == CW'(NB)) state_d = rnes_pkg::ST_DRAIN;
			rnes_pkg::ST_DRAIN:    state_d = last_q ? rnes_pkg::ST_REG : rnes_pkg::ST_IDLE;
			rnes_pkg::ST_REG:      state_d = rnes_pkg::ST_PIV_INIT;
			rnes_pkg::ST_PIV_INIT: state_d = rnes_pkg::ST_PIV_SCAN;
			rnes_pkg::ST_PIV_SCAN: if (r_q >= n) state_d = rnes_pkg::ST_SWAP;
			rnes_pkg::ST_SWAP:     state_d = rnes_pkg::ST_CHECK;
			rnes_pkg::ST_CHECK: begin
				if (!diag_zero && col_more) state_d = rnes_pkg::ST_DIV_GO;
				else if (col_more) state_d = rnes_pkg::ST_PIV_INIT;
				else state_d = rnes_pkg::ST_BK_CHECK;
			end
			rnes_pkg::ST_DIV_GO:   state_d = rnes_pkg::ST_DIV_WAIT;
			rnes_pkg::ST_DIV_WAIT: if (div_rsp.done) state_d = rnes_pkg::ST_MUL_GO;
			rnes_pkg::ST_MUL_GO:   state_d = rnes_pkg::ST_MUL_WAIT;
			rnes_pkg::ST_MUL_WAIT: begin
				if (mul_rsp.done) begin
					if (k_more) state_d = rnes_pkg::ST_MUL_GO;
					else if (r_more) state_d = rnes_pkg::ST_DIV_GO;
					else if (col_more) state_d = rnes_pkg::ST_PIV_INIT;
					else state_d = rnes_pkg::ST_BK_CHECK;
				end
			end
			rnes_pkg::ST_BK_CHECK: begin
				if (!diag_zero) state_d = rnes_pkg::ST_BK_DIV_GO;
				else if (col_q == '0) state_d = rnes_pkg::ST_EMIT;
			end
			rnes_pkg::ST_BK_DIV_GO:   state_d = rnes_pkg::ST_BK_DIV_WAIT;
			rnes_pkg::ST_BK_DIV_WAIT: begin
				if (div_rsp.done)
					state_d = (col_q == '0) ? rnes_pkg::ST_EMIT : rnes_pkg::ST_BK_MUL_GO;
			end
			rnes_pkg::ST_BK_MUL_GO:   state_d = rnes_pkg::ST_BK_MUL_WAIT;
			rnes_pkg::ST_BK_MUL_WAIT: begin
				if (mul_rsp.done)
					state_d = (r_q == '0) ? rnes_pkg::ST_BK_CHECK : rnes_pkg::ST_BK_MUL_GO;
			end
			rnes_pkg::ST_EMIT: if (i_q + CW'(1) >= n) state_d = rnes_pkg::ST_IDLE;
			default: state_d = rnes_pkg::ST_IDLE;
		endcase
	end

	// Arithmetic unit requests.
	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			rnes_pkg::ST_DIV_GO: begin
				div_req.start = 1'b1;
				div_req.a     = mat_q[r_q[IW-1:0]][col_q[IW-1:0]];
				div_req.b     = mat_q[col_q[IW-1:0]][col_q[IW-1:0]];
			end
			rnes_pkg::ST_BK_DIV_GO: begin
				div_req.start = 1'b1;
				div_req.a     = vec_q[col_q[IW-1:0]];
				div_req.b     = mat_q[col_q[IW-1:0]][col_q[IW-1:0]];
			end
			rnes_pkg::ST_MUL_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = f_q;
				mul_req.b     = k_more ? mat_q[col_q[IW-1:0]][k_q[IW-1:0]]
				                       : vec_q[col_q[IW-1:0]];
			end
			rnes_pkg::ST_BK_MUL_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = mat_q[r_q[IW-1:0]][col_q[IW-1:0]];
				mul_req.b     = vec_q[col_q[IW-1:0]];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rnes_pkg::ST_IDLE;
			reg_q      <= '0;
			bcount_q   <= 4'(NB);
			v_s1       <= 1'b0;
			coef_valid <= 1'b0;
			for (int a = 0; a < NB; a++) begin
				vec_q[a] <= '0;
				for (int b = 0; b < NB; b++) mat_q[a][b] <= '0;
			end
		end else begin
			state_q    <= state_d;
			coef_valid <= 1'b0;
			v_s1       <= state_q == rnes_pkg::ST_ACC;
			j_s1       <= j_q;

			if (cfg_wr_en) begin
				unique case (cfg_index)
					rnes_pkg::REG_REGULARIZATION: reg_q    <= cfg_data;
					rnes_pkg::REG_BASIS_COUNT:    bcount_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			// Write back lane sums in the cycle after the product.
			if (v_s1) begin
				for (int a = 0; a < NB; a++) begin
					if (j_s1 < CW'(NB)) mat_q[a][j_s1[IW-1:0]] <= lane_sum[a];
					else vec_q[a] <= lane_sum[a];
				end
			end

			unique case (state_q)
				rnes_pkg::ST_IDLE: begin
					if (accept) begin
						row_q  <= '{elem_0, elem_1, elem_2, elem_3,
						            elem_4, elem_5, elem_6, elem_7};
						t_q    <= rhs;
						last_q <= last_row;
						j_q    <= '0;
					end
				end
				rnes_pkg::ST_ACC:   j_q <= j_q + CW'(1);
				rnes_pkg::ST_DRAIN: col_q <= '0;
				rnes_pkg::ST_REG: begin
					i_q <= '0;
					for (int a = 0; a < NB; a++)
						if (CW'(a) < n)
							mat_q[a][a] <= rnes_pkg::sat_add(mat_q[a][a], {16'd0, reg_q, 16'd0});
				end
				rnes_pkg::ST_PIV_INIT: begin
					piv_q <= col_q;
					r_q   <= col_q + CW'(1);
				end
				rnes_pkg::ST_PIV_SCAN: begin
					if (r_q < n) begin
						if (rnes_pkg::mag(mat_q[r_q[IW-1:0]][col_q[IW-1:0]]) >
						    rnes_pkg::mag(mat_q[piv_q[IW-1:0]][col_q[IW-1:0]]))
							piv_q <= r_q;
						r_q <= r_q + CW'(1);
					end
				end
				rnes_pkg::ST_SWAP: begin
					if (piv_q != col_q) begin
						mat_q[col_q[IW-1:0]] <= mat_q[piv_q[IW-1:0]];
						mat_q[piv_q[IW-1:0]] <= mat_q[col_q[IW-1:0]];
						vec_q[col_q[IW-1:0]] <= vec_q[piv_q[IW-1:0]];
						vec_q[piv_q[IW-1:0]] <= vec_q[col_q[IW-1:0]];
					end
				end
				rnes_pkg::ST_CHECK: begin
					r_q <= col_q + CW'(1);
					if (state_d == rnes_pkg::ST_PIV_INIT) col_q <= col_q + CW'(1);
					if (state_d == rnes_pkg::ST_BK_CHECK) col_q <= n - CW'(1);
				end
				rnes_pkg::ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						f_q <= div_rsp.res;
						k_q <= col_q;
					end
				end
				rnes_pkg::ST_MUL_WAIT: begin
					if (mul_rsp.done) begin
						if (k_more)
							mat_q[r_q[IW-1:0]][k_q[IW-1:0]] <= rnes_pkg::sat_sub(
								mat_q[r_q[IW-1:0]][k_q[IW-1:0]], mul_rsp.res);
						else
							vec_q[r_q[IW-1:0]] <= rnes_pkg::sat_sub(
								vec_q[r_q[IW-1:0]], mul_rsp.res);
						k_q <= k_q + CW'(1);
						if (state_d == rnes_pkg::ST_DIV_GO) r_q <= r_q + CW'(1);
						if (state_d == rnes_pkg::ST_PIV_INIT) col_q <= col_q + CW'(1);
						if (state_d == rnes_pkg::ST_BK_CHECK) col_q <= n - CW'(1);
					end
				end
				rnes_pkg::ST_BK_CHECK: begin
					if (state_d == rnes_pkg::ST_BK_CHECK) col_q <= col_q - CW'(1);
				end
				rnes_pkg::ST_BK_DIV_WAIT: begin
					if (div_rsp.done) begin
						vec_q[col_q[IW-1:0]] <= div_rsp.res;
						r_q <= col_q - CW'(1);
					end
				end
				rnes_pkg::ST_BK_MUL_WAIT: begin
					if (mul_rsp.done) begin
						vec_q[r_q[IW-1:0]] <= rnes_pkg::sat_sub(vec_q[r_q[IW-1:0]], mul_rsp.res);
						r_q <= r_q - CW'(1);
						if (state_d == rnes_pkg::ST_BK_CHECK) col_q <= col_q - CW'(1);
					end
				end
				rnes_pkg::ST_EMIT: begin
					coef_valid <= 1'b1;
					coef_index <= i_q[2:0];
					coef_value <= vec_q[i_q[IW-1:0]];
					zero_pivot <= mat_q[i_q[IW-1:0]][i_q[IW-1:0]] == 64'sd0;
					last_coef  <= state_d == rnes_pkg::ST_IDLE;
					i_q        <= i_q + CW'(1);
					// Drop both stores once the final coefficient is out.
					if (state_d == rnes_pkg::ST_IDLE) begin
						for (int a = 0; a < NB; a++) begin
							vec_q[a] <= '0;
							for (int b = 0; b < NB; b++) mat_q[a][b] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider started together");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && last_coef |=> !coef_valid)
		else $error("coefficient after the final one");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> $past(state_q) == rnes_pkg::ST_EMIT)
		else $error("result strobe outside emission");
endmodule

### rtl/rnes_lane.sv
// One row lane: Q16.16 product, then saturating add onto the stored entry.
module rnes_lane (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [63:0] acc,
	output logic signed [63:0] sum
);
	logic signed [63:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign sum = rnes_pkg::sat_add(acc, prod_s1);
endmodule

### rtl/rnes_mul.sv
// Q32.32 multiply: four 32x32 partial products, then round and saturate.
module rnes_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rnes_pkg::op_req_t    req,
	output rnes_pkg::op_rsp_t    rsp
);
	logic [63:0]  ma_q, mb_q;
	logic         neg_q, run_q;
	logic [2:0]   cnt_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [64:0]  rnd;
	logic         ovf;

	always_comb begin
		pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = pa * pb;
		case (cnt_q)
			3'd0:    pp_sh = {64'd0, pp};
			3'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		rnd = {1'b0, acc_q[95:32]} + 65'(acc_q[31]);
		ovf = (|acc_q[127:96]) | rnd[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			rsp   <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				ma_q  <= rnes_pkg::mag(req.a);
				mb_q  <= rnes_pkg::mag(req.b);
				neg_q <= req.a[63] ^ req.b[63];
				acc_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == 3'd4) begin
					run_q    <= 1'b0;
					rsp.done <= 1'b1;
					rsp.res  <= rnes_pkg::to_signed(rnd[63:0], neg_q, ovf);
				end else begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end
endmodule

### rtl/rnes_div.sv
// Q32.32 divide: restoring, one quotient bit per cycle, then round and saturate.
module rnes_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rnes_pkg::op_req_t    req,
	output rnes_pkg::op_rsp_t    rsp
);
	logic [63:0]  mb_q, rem_q;
	logic [127:0] num_q, q_q;
	logic         neg_q, run_q;
	logic [7:0]   cnt_q;
	logic [64:0]  rem_n, ql;
	logic         ge, ovf;

	always_comb begin
		rem_n = {rem_q, num_q[127]};
		ge    = rem_n >= {1'b0, mb_q};
		ql    = {1'b0, q_q[63:0]} + 65'(rem_q >= (mb_q - rem_q));
		ovf   = (|q_q[127:64]) | ql[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			rsp   <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				num_q <= {32'd0, rnes_pkg::mag(req.a), 32'd0};
				mb_q  <= rnes_pkg::mag(req.b);
				neg_q <= req.a[63] ^ req.b[63];
				rem_q <= '0;
				q_q   <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == 8'd128) begin
					run_q    <= 1'b0;
					rsp.done <= 1'b1;
					rsp.res  <= rnes_pkg::to_signed(ql[63:0], neg_q, ovf);
				end else begin
					rem_q <= ge ? 64'(rem_n - {1'b0, mb_q}) : rem_n[63:0];
					q_q   <= {q_q[126:0], ge};
					num_q <= {num_q[126:0], 1'b0};
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end
endmodule
